>>> hdl/kfat_pkg.sv
package kfat_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 3;
    localparam int DT_W        = 17;
    localparam int ACT_W       = 5;

    // Q1.16 step of exactly 1.0
    localparam logic [DT_W-1:0] DT_MAX = 17'd65536;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPLY = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_INTEG = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STS_OK       = 3'd0,
        STS_INVALID  = 3'd1,
        STS_BAD_BODY = 3'd2,
        STS_STATIC   = 3'd3,
        STS_UNKNOWN  = 3'd4,
        STS_FULL     = 3'd5,
        STS_OVERFLOW = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        TBL_NONE,
        TBL_WRITE,
        TBL_ALLOC,
        TBL_FREE
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t          op;
        logic [IDX_W-1:0] idx;
        logic [31:0]      key;
        logic [31:0]      fx;
        logic [31:0]      fz;
    } tbl_wr_t;

    typedef struct packed {
        logic             hit;
        logic             free_ok;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] count_next;
    } tbl_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SEL,
        S_MUL1,
        S_MUL2,
        S_ADD,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic look;
        logic sel;
        logic mul1;
        logic mul2;
        logic add;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_mul;
    } dp_stat_t;

    // encode a one-hot (or empty) vector; bits are ORed, no priority chain
    function automatic logic [IDX_W-1:0] onehot_idx(input logic [MAX_ENTRIES-1:0] oh);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (oh[i])
            begin
                r = r | IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/kfat_table.sv
module kfat_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                look,
    input  logic                sel,
    input  logic [31:0]         key,
    input  kfat_pkg::tbl_wr_t   wr,
    output kfat_pkg::tbl_stat_t stat,
    output logic [31:0]         rd_fx,
    output logic [31:0]         rd_fz
);
    import kfat_pkg::*;

    logic [MAX_ENTRIES-1:0] used_reg;
    logic [MAX_ENTRIES-1:0] used_next;
    logic [MAX_ENTRIES-1:0] match_reg;
    logic [MAX_ENTRIES-1:0] match_next;
    logic [MAX_ENTRIES-1:0] free_reg;
    logic [MAX_ENTRIES-1:0] free_low;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [31:0]            slot_key_reg [MAX_ENTRIES];
    logic [31:0]            slot_fx_reg  [MAX_ENTRIES];
    logic [31:0]            slot_fz_reg  [MAX_ENTRIES];
    logic [31:0]            rd_fx_reg;
    logic [31:0]            rd_fz_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match_next[i] = used_reg[i] && (slot_key_reg[i] == key);
        end
    end

    // isolate the lowest free slot
    assign free_low = free_reg & (~free_reg + 1'b1);

    always_comb
    begin
        used_next  = used_reg;
        count_next = count_reg;
        case (wr.op)
            TBL_ALLOC:
            begin
                used_next[wr.idx] = 1'b1;
                count_next        = count_reg + 1'b1;
            end
            TBL_FREE:
            begin
                used_next[wr.idx] = 1'b0;
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                used_next  = used_reg;
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            count_reg <= '0;
            match_reg <= '0;
            free_reg  <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            count_reg <= count_next;
            if (look)
            begin
                match_reg <= match_next;
                free_reg  <= ~used_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            rd_fx_reg <= slot_fx_reg[stat.hit_idx];
            rd_fz_reg <= slot_fz_reg[stat.hit_idx];
        end
        case (wr.op)
            TBL_WRITE:
            begin
                slot_fx_reg[wr.idx] <= wr.fx;
                slot_fz_reg[wr.idx] <= wr.fz;
            end
            TBL_ALLOC:
            begin
                slot_key_reg[wr.idx] <= wr.key;
                slot_fx_reg[wr.idx]  <= wr.fx;
                slot_fz_reg[wr.idx]  <= wr.fz;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.hit        = |match_reg;
    assign stat.free_ok    = |free_reg;
    assign stat.hit_idx    = onehot_idx(match_reg);
    assign stat.free_idx   = onehot_idx(free_low);
    assign stat.count_next = count_next;
    assign rd_fx           = rd_fx_reg;
    assign rd_fz           = rd_fz_reg;

endmodule

>>> hdl/kfat_ctrl.sv
module kfat_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  kfat_pkg::dp_stat_t dstat,
    output kfat_pkg::ctl_cmd_t ctl,
    output logic               busy
);
    import kfat_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                ctl.look   = 1'b1;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                ctl.sel    = 1'b1;
                state_next = dstat.need_mul ? S_MUL1 : S_COMMIT;
            end
            S_MUL1:
            begin
                ctl.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                ctl.mul2   = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                ctl.add    = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                ctl.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> hdl/kfat_dp.sv
module kfat_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  kfat_pkg::ctl_cmd_t               ctl,
    output kfat_pkg::dp_stat_t               dstat,
    input  logic [kfat_pkg::CMD_W-1:0]       cmd,
    input  logic [31:0]                      entity_id,
    input  logic signed [31:0]               force_x,
    input  logic signed [31:0]               force_z,
    input  logic                             body_found,
    input  logic signed [31:0]               inv_mass,
    input  logic signed [31:0]               body_radius,
    input  logic signed [31:0]               vel_x,
    input  logic signed [31:0]               vel_z,
    input  logic [kfat_pkg::DT_W-1:0]        time_step,
    output logic                             done,
    output logic [kfat_pkg::STAT_W-1:0]      status,
    output logic signed [31:0]               new_vel_x,
    output logic signed [31:0]               new_vel_z,
    output logic [kfat_pkg::ACT_W-1:0]       active_entries
);
    import kfat_pkg::*;

    localparam logic [49:0] RND_HALF = 50'h0_0000_8000_0000;

    logic [CMD_W-1:0]   cmd_reg;
    logic [31:0]        key_reg;
    logic signed [31:0] fx_reg;
    logic signed [31:0] fz_reg;
    logic               found_reg;
    logic signed [31:0] im_reg;
    logic signed [31:0] rad_reg;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vz_reg;
    logic [DT_W-1:0]    dt_reg;

    logic signed [63:0] px_reg;
    logic signed [63:0] pz_reg;
    logic signed [49:0] hx_reg;
    logic signed [49:0] hz_reg;
    logic [48:0]        lx_reg;
    logic [48:0]        lz_reg;
    logic signed [51:0] dx_reg;
    logic signed [51:0] dz_reg;

    logic               done_reg;
    logic [STAT_W-1:0]  status_reg;
    logic signed [31:0] nvx_reg;
    logic signed [31:0] nvz_reg;
    logic [ACT_W-1:0]   active_reg;

    tbl_wr_t            wr;
    tbl_stat_t          tstat;
    logic [31:0]        rd_fx;
    logic [31:0]        rd_fz;

    cmd_t               op;
    logic               dt_ok;
    logic signed [31:0] old_fx;
    logic signed [31:0] old_fz;
    logic               old_zero;
    logic [32:0]        sum_x;
    logic [32:0]        sum_z;
    logic               ovf_apply;
    logic [49:0]        lrx;
    logic [49:0]        lrz;
    logic [51:0]        tx;
    logic [51:0]        tz;
    logic               ovf_integ;
    status_t            status_next;
    logic signed [31:0] nvx_next;
    logic signed [31:0] nvz_next;
    tbl_op_t            wr_op;

    kfat_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .look  (ctl.look),
        .sel   (ctl.sel),
        .key   (key_reg),
        .wr    (wr),
        .stat  (tstat),
        .rd_fx (rd_fx),
        .rd_fz (rd_fz)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd;
            key_reg   <= entity_id;
            fx_reg    <= force_x;
            fz_reg    <= force_z;
            found_reg <= body_found;
            im_reg    <= inv_mass;
            rad_reg   <= body_radius;
            vx_reg    <= vel_x;
            vz_reg    <= vel_z;
            dt_reg    <= time_step;
        end
        if (ctl.mul1)
        begin
            px_reg <= old_fx * im_reg;
            pz_reg <= old_fz * im_reg;
        end
        // split the 64 x 17 product into a signed high and unsigned low part
        if (ctl.mul2)
        begin
            hx_reg <= $signed(px_reg[63:32]) * $signed({1'b0, dt_reg});
            hz_reg <= $signed(pz_reg[63:32]) * $signed({1'b0, dt_reg});
            lx_reg <= px_reg[31:0] * dt_reg;
            lz_reg <= pz_reg[31:0] * dt_reg;
        end
        if (ctl.add)
        begin
            dx_reg <= {{2{hx_reg[49]}}, hx_reg} + {34'd0, lrx[49:32]};
            dz_reg <= {{2{hz_reg[49]}}, hz_reg} + {34'd0, lrz[49:32]};
        end
        if (ctl.commit)
        begin
            status_reg <= status_next;
            nvx_reg    <= nvx_next;
            nvz_reg    <= nvz_next;
            active_reg <= ACT_W'(tstat.count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.commit;
        end
    end

    assign op       = cmd_t'(cmd_reg);
    assign dt_ok    = (dt_reg != '0) && (dt_reg <= DT_MAX);
    assign old_fx   = tstat.hit ? $signed(rd_fx) : 32'sd0;
    assign old_fz   = tstat.hit ? $signed(rd_fz) : 32'sd0;
    assign old_zero = (old_fx == 32'sd0) && (old_fz == 32'sd0);

    assign sum_x     = {old_fx[31], old_fx} + {fx_reg[31], fx_reg};
    assign sum_z     = {old_fz[31], old_fz} + {fz_reg[31], fz_reg};
    assign ovf_apply = (sum_x[32] ^ sum_x[31]) || (sum_z[32] ^ sum_z[31]);

    // round half up at bit 31 of the low partial product
    assign lrx = {1'b0, lx_reg} + RND_HALF;
    assign lrz = {1'b0, lz_reg} + RND_HALF;

    assign tx        = {{20{vx_reg[31]}}, vx_reg} + dx_reg;
    assign tz        = {{20{vz_reg[31]}}, vz_reg} + dz_reg;
    assign ovf_integ = (tx[51:31] != {21{tx[31]}}) || (tz[51:31] != {21{tz[31]}});

    assign dstat.need_mul = (op == CMD_INTEG) && dt_ok && tstat.hit && found_reg
                            && (im_reg > 32'sd0);

    always_comb
    begin
        status_next = STS_OK;
        nvx_next    = vx_reg;
        nvz_next    = vz_reg;
        wr_op       = TBL_NONE;
        wr.idx      = tstat.hit ? tstat.hit_idx : tstat.free_idx;
        wr.key      = key_reg;
        wr.fx       = sum_x[31:0];
        wr.fz       = sum_z[31:0];
        case (op)
            CMD_APPLY:
            begin
                if (!found_reg)
                begin
                    status_next = STS_UNKNOWN;
                end
                else if ((im_reg < 32'sd0) || (rad_reg <= 32'sd0))
                begin
                    status_next = STS_BAD_BODY;
                end
                else if (im_reg == 32'sd0)
                begin
                    status_next = STS_STATIC;
                end
                else if (!tstat.hit && !tstat.free_ok)
                begin
                    status_next = STS_FULL;
                end
                else if (ovf_apply)
                begin
                    status_next = STS_OVERFLOW;
                    // drop an entry that held no force
                    if (tstat.hit && old_zero)
                    begin
                        wr_op = TBL_FREE;
                    end
                end
                else
                begin
                    wr_op = tstat.hit ? TBL_WRITE : TBL_ALLOC;
                end
            end
            CMD_CLEAR:
            begin
                if (!tstat.hit)
                begin
                    status_next = STS_UNKNOWN;
                end
                else
                begin
                    wr_op = TBL_FREE;
                end
            end
            CMD_INTEG:
            begin
                wr.fx = '0;
                wr.fz = '0;
                if (!dt_ok)
                begin
                    status_next = STS_INVALID;
                end
                else if (!tstat.hit)
                begin
                    status_next = STS_OK;
                end
                else if (!found_reg)
                begin
                    status_next = STS_UNKNOWN;
                end
                else if (im_reg == 32'sd0)
                begin
                    status_next = STS_STATIC;
                end
                else if (im_reg < 32'sd0)
                begin
                    status_next = STS_BAD_BODY;
                end
                else if (ovf_integ)
                begin
                    status_next = STS_OVERFLOW;
                end
                else
                begin
                    nvx_next = tx[31:0];
                    nvz_next = tz[31:0];
                    wr_op    = TBL_WRITE;
                end
            end
            default:
            begin
                status_next = STS_INVALID;
            end
        endcase
        wr.op = ctl.commit ? wr_op : TBL_NONE;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign new_vel_x      = nvx_reg;
    assign new_vel_z      = nvz_reg;
    assign active_entries = active_reg;

endmodule

>>> hdl/keyed_force_accumulator_table_core.sv
// channel  dir  handshake                  word
// command  in   start high, busy low       cmd, entity_id, force_x, force_z, body_found,
//                                          inv_mass, body_radius, vel_x, vel_z, time_step
// result   out  done high for one cycle    status, new_vel_x, new_vel_z, active_entries
//
// A word that skips the multiply goes from the accept edge through key search, slot read,
// then the add, range check and table write, and ends with done.
// Integrate with a live entry, a valid step, a found body and inverse mass above zero
// adds two multiply stages and one rounding add after the slot read.
// busy drops in the cycle done is high, so the next word can enter then.
// Reset clears the slot valid bits and the entry count at once; no sweep is needed.
// The receiver cannot stall: each result is valid for its single done cycle only.
module keyed_force_accumulator_table_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [kfat_pkg::CMD_W-1:0]       cmd,
    input  logic [31:0]                      entity_id,
    input  logic signed [31:0]               force_x,
    input  logic signed [31:0]               force_z,
    input  logic                             body_found,
    input  logic signed [31:0]               inv_mass,
    input  logic signed [31:0]               body_radius,
    input  logic signed [31:0]               vel_x,
    input  logic signed [31:0]               vel_z,
    input  logic [kfat_pkg::DT_W-1:0]        time_step,
    output logic                             done,
    output logic [kfat_pkg::STAT_W-1:0]      status,
    output logic signed [31:0]               new_vel_x,
    output logic signed [31:0]               new_vel_z,
    output logic [kfat_pkg::ACT_W-1:0]       active_entries
);
    import kfat_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t dstat;

    kfat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .dstat (dstat),
        .ctl   (ctl),
        .busy  (busy)
    );

    kfat_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .dstat          (dstat),
        .cmd            (cmd),
        .entity_id      (entity_id),
        .force_x        (force_x),
        .force_z        (force_z),
        .body_found     (body_found),
        .inv_mass       (inv_mass),
        .body_radius    (body_radius),
        .vel_x          (vel_x),
        .vel_z          (vel_z),
        .time_step      (time_step),
        .done           (done),
        .status         (status),
        .new_vel_x      (new_vel_x),
        .new_vel_z      (new_vel_z),
        .active_entries (active_entries)
    );

endmodule
